@@ hdl/alle_pkg.sv @@
// Shared types and constants for the array linked list engine.
// Used by array_linked_list_engine; depends on nothing.
package alle_pkg;

  localparam int NODES  = 256;
  localparam int IDX_W  = 8;
  localparam int LINK_W = 9;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    FN_INSERT,
    FN_ERASE,
    FN_READ,
    FN_FIND
  } func_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_BAD,
    STS_FULL
  } status_t;

  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [IDX_W-1:0]  prev;
    logic              used;
  } link_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_INS_FREE,
    S_INS_RDAFT,
    S_INS_AFT,
    S_INS_NODE,
    S_ERS_AFT,
    S_ERS_RDBEF,
    S_ERS_BEF,
    S_ERS_WALK,
    S_ERS_LINK,
    S_FIND,
    S_FIND_WAIT
  } state_t;

endpackage

@@ hdl/alle_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
// Depends on nothing; a read of the address written in the same cycle gives old data.
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/array_linked_list_engine.sv @@
// Top level of the array linked list engine: sequencer around a link RAM and a data RAM.
// Depends on alle_pkg and alle_ram.
//
// After reset the block initializes the link table and keeps busy high
// until that pass ends. A request is taken when start is high and busy is low; the result
// appears for one cycle with done high and cannot be held off, so it must be captured then.
// Cost per request is set by the single read and write port of the link RAM. A full-table
// or bad find is answered straight from idle, an erase walks the free list to find its
// sorted place, and a find follows links (up to about half the stored count). first_node,
// last_node and node_count are valid whenever done is high.
module array_linked_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func,
  input  logic [alle_pkg::IDX_W-1:0]   node_index,
  input  logic [alle_pkg::DATA_W-1:0]  new_value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [alle_pkg::DATA_W-1:0]  read_data,
  output logic [alle_pkg::IDX_W-1:0]   position,
  output logic [alle_pkg::IDX_W-1:0]   first_node,
  output logic [alle_pkg::IDX_W-1:0]   last_node,
  output logic [alle_pkg::IDX_W-1:0]   node_count
);

  alle_pkg::state_t state, state_next;
  alle_pkg::func_t  fn, fn_next;
  alle_pkg::link_t  e_idx, e_idx_next;
  alle_pkg::link_t  lk_wdata, lk_rdata;

  logic [alle_pkg::IDX_W-1:0]  clr_idx, clr_idx_next;
  logic [alle_pkg::IDX_W-1:0]  idx, idx_next;
  logic [alle_pkg::DATA_W-1:0] val, val_next;
  logic [alle_pkg::IDX_W-1:0]  nreg, nreg_next;
  logic [alle_pkg::IDX_W-1:0]  pred, pred_next;
  logic [alle_pkg::LINK_W-1:0] succ, succ_next;
  logic [alle_pkg::IDX_W-1:0]  cur, cur_next;
  logic [alle_pkg::LINK_W-1:0] steps, steps_next;
  logic                        fwd, fwd_next;
  logic [alle_pkg::LINK_W-1:0] free_head, free_head_next;
  logic [alle_pkg::IDX_W-1:0]  count, count_next;
  logic [alle_pkg::IDX_W-1:0]  head, tail;
  logic                        done_next;
  logic [1:0]                  status_next;
  logic [alle_pkg::DATA_W-1:0] read_data_next;
  logic [alle_pkg::IDX_W-1:0]  position_next;

  logic                        lk_we, dt_we;
  logic [alle_pkg::IDX_W-1:0]  lk_waddr, lk_raddr;
  logic [alle_pkg::DATA_W-1:0] dt_rdata;

  alle_ram #(
    .WIDTH($bits(alle_pkg::link_t)),
    .DEPTH(alle_pkg::NODES)
  ) u_link_ram (
    .clk  (clk),
    .we   (lk_we),
    .waddr(lk_waddr),
    .wdata(lk_wdata),
    .raddr(lk_raddr),
    .rdata(lk_rdata)
  );

  alle_ram #(
    .WIDTH(alle_pkg::DATA_W),
    .DEPTH(alle_pkg::NODES)
  ) u_data_ram (
    .clk  (clk),
    .we   (dt_we),
    .waddr(nreg),
    .wdata(val),
    .raddr(node_index),
    .rdata(dt_rdata)
  );

  assign busy       = (state != alle_pkg::S_IDLE);
  assign first_node = head;
  assign last_node  = tail;
  assign node_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alle_pkg::S_CLEAR;
      clr_idx   <= '0;
      free_head <= alle_pkg::LINK_W'(1);
      count     <= '0;
      done      <= 1'b0;
      head      <= '0;
      tail      <= '0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      free_head <= free_head_next;
      count     <= count_next;
      done      <= done_next;
      if (lk_we && lk_waddr == '0) begin
        head <= lk_wdata.next[alle_pkg::IDX_W-1:0];
        tail <= lk_wdata.prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    fn        <= fn_next;
    e_idx     <= e_idx_next;
    idx       <= idx_next;
    val       <= val_next;
    nreg      <= nreg_next;
    pred      <= pred_next;
    succ      <= succ_next;
    cur       <= cur_next;
    steps     <= steps_next;
    fwd       <= fwd_next;
    status    <= status_next;
    read_data <= read_data_next;
    position  <= position_next;
  end

  always_comb begin
    state_next     = state;
    fn_next        = fn;
    e_idx_next     = e_idx;
    clr_idx_next   = clr_idx;
    idx_next       = idx;
    val_next       = val;
    nreg_next      = nreg;
    pred_next      = pred;
    succ_next      = succ;
    cur_next       = cur;
    steps_next     = steps;
    fwd_next       = fwd;
    free_head_next = free_head;
    count_next     = count;
    done_next      = 1'b0;
    status_next    = status;
    read_data_next = read_data;
    position_next  = position;
    lk_we          = 1'b0;
    lk_waddr       = idx;
    lk_wdata       = e_idx;
    lk_raddr       = idx;
    dt_we          = 1'b0;

    unique case (state)
      alle_pkg::S_CLEAR: begin
        lk_we         = 1'b1;
        lk_waddr      = clr_idx;
        lk_wdata.next = (clr_idx == '0) ? '0 :
                        alle_pkg::LINK_W'(clr_idx) + alle_pkg::LINK_W'(1);
        lk_wdata.prev = '0;
        lk_wdata.used = (clr_idx == '0);
        clr_idx_next  = clr_idx + alle_pkg::IDX_W'(1);
        if (clr_idx == alle_pkg::IDX_W'(alle_pkg::NODES - 1)) begin
          state_next = alle_pkg::S_IDLE;
        end
      end

      alle_pkg::S_IDLE: begin
        lk_raddr = node_index;
        if (start) begin
          fn_next  = alle_pkg::func_t'(func);
          idx_next = node_index;
          val_next = new_value;
          case (alle_pkg::func_t'(func))
            alle_pkg::FN_INSERT: begin
              if (free_head == alle_pkg::LINK_W'(alle_pkg::NODES)) begin
                done_next      = 1'b1;
                status_next    = alle_pkg::STS_FULL;
                read_data_next = '0;
                position_next  = '0;
              end else begin
                state_next = alle_pkg::S_CHECK;
              end
            end
            alle_pkg::FN_FIND: begin
              if (node_index > count) begin
                done_next      = 1'b1;
                status_next    = alle_pkg::STS_BAD;
                read_data_next = '0;
                position_next  = '0;
              end else begin
                cur_next = '0;
                if (node_index < (count >> 1)) begin
                  steps_next = {1'b0, node_index};
                  fwd_next   = 1'b1;
                end else begin
                  steps_next = {1'b0, count} - {1'b0, node_index} + alle_pkg::LINK_W'(1);
                  fwd_next   = 1'b0;
                end
                state_next = alle_pkg::S_FIND;
              end
            end
            default: begin
              state_next = alle_pkg::S_CHECK;
            end
          endcase
        end
      end

      alle_pkg::S_CHECK: begin
        e_idx_next = lk_rdata;
        case (fn)
          alle_pkg::FN_READ: begin
            done_next      = 1'b1;
            status_next    = lk_rdata.used ? alle_pkg::STS_OK : alle_pkg::STS_BAD;
            read_data_next = lk_rdata.used ? dt_rdata : '0;
            position_next  = '0;
            state_next     = alle_pkg::S_IDLE;
          end
          alle_pkg::FN_INSERT: begin
            if (!lk_rdata.used) begin
              done_next      = 1'b1;
              status_next    = alle_pkg::STS_BAD;
              read_data_next = '0;
              position_next  = '0;
              state_next     = alle_pkg::S_IDLE;
            end else begin
              nreg_next  = free_head[alle_pkg::IDX_W-1:0];
              lk_raddr   = free_head[alle_pkg::IDX_W-1:0];
              state_next = alle_pkg::S_INS_FREE;
            end
          end
          default: begin
            if (idx == '0 || !lk_rdata.used) begin
              done_next      = 1'b1;
              status_next    = alle_pkg::STS_BAD;
              read_data_next = '0;
              position_next  = '0;
              state_next     = alle_pkg::S_IDLE;
            end else begin
              lk_raddr   = lk_rdata.next[alle_pkg::IDX_W-1:0];
              state_next = alle_pkg::S_ERS_AFT;
            end
          end
        endcase
      end

      alle_pkg::S_INS_FREE: begin
        free_head_next = lk_rdata.next;
        lk_we          = 1'b1;
        lk_waddr       = idx;
        lk_wdata       = e_idx;
        lk_wdata.next  = {1'b0, nreg};
        state_next     = alle_pkg::S_INS_RDAFT;
      end

      alle_pkg::S_INS_RDAFT: begin
        lk_raddr   = e_idx.next[alle_pkg::IDX_W-1:0];
        state_next = alle_pkg::S_INS_AFT;
      end

      alle_pkg::S_INS_AFT: begin
        lk_we         = 1'b1;
        lk_waddr      = e_idx.next[alle_pkg::IDX_W-1:0];
        lk_wdata      = lk_rdata;
        lk_wdata.prev = nreg;
        state_next    = alle_pkg::S_INS_NODE;
      end

      alle_pkg::S_INS_NODE: begin
        lk_we          = 1'b1;
        lk_waddr       = nreg;
        lk_wdata.next  = {1'b0, e_idx.next[alle_pkg::IDX_W-1:0]};
        lk_wdata.prev  = idx;
        lk_wdata.used  = 1'b1;
        dt_we          = 1'b1;
        count_next     = count + alle_pkg::IDX_W'(1);
        done_next      = 1'b1;
        status_next    = alle_pkg::STS_OK;
        read_data_next = '0;
        position_next  = nreg;
        state_next     = alle_pkg::S_IDLE;
      end

      alle_pkg::S_ERS_AFT: begin
        lk_we         = 1'b1;
        lk_waddr      = e_idx.next[alle_pkg::IDX_W-1:0];
        lk_wdata      = lk_rdata;
        lk_wdata.prev = e_idx.prev;
        state_next    = alle_pkg::S_ERS_RDBEF;
      end

      alle_pkg::S_ERS_RDBEF: begin
        lk_raddr   = e_idx.prev;
        state_next = alle_pkg::S_ERS_BEF;
      end

      alle_pkg::S_ERS_BEF: begin
        lk_we         = 1'b1;
        lk_waddr      = e_idx.prev;
        lk_wdata      = lk_rdata;
        lk_wdata.next = {1'b0, e_idx.next[alle_pkg::IDX_W-1:0]};
        if ({1'b0, idx} < free_head) begin
          succ_next      = free_head;
          free_head_next = {1'b0, idx};
          state_next     = alle_pkg::S_ERS_LINK;
        end else begin
          pred_next  = free_head[alle_pkg::IDX_W-1:0];
          lk_raddr   = free_head[alle_pkg::IDX_W-1:0];
          state_next = alle_pkg::S_ERS_WALK;
        end
      end

      alle_pkg::S_ERS_WALK: begin
        if ({1'b0, idx} < lk_rdata.next) begin
          lk_we         = 1'b1;
          lk_waddr      = pred;
          lk_wdata      = lk_rdata;
          lk_wdata.next = {1'b0, idx};
          succ_next     = lk_rdata.next;
          state_next    = alle_pkg::S_ERS_LINK;
        end else begin
          pred_next = lk_rdata.next[alle_pkg::IDX_W-1:0];
          lk_raddr  = lk_rdata.next[alle_pkg::IDX_W-1:0];
        end
      end

      alle_pkg::S_ERS_LINK: begin
        lk_we          = 1'b1;
        lk_waddr       = idx;
        lk_wdata.next  = succ;
        lk_wdata.prev  = '0;
        lk_wdata.used  = 1'b0;
        count_next     = count - alle_pkg::IDX_W'(1);
        done_next      = 1'b1;
        status_next    = alle_pkg::STS_OK;
        read_data_next = '0;
        position_next  = '0;
        state_next     = alle_pkg::S_IDLE;
      end

      alle_pkg::S_FIND: begin
        if (steps == '0) begin
          done_next      = 1'b1;
          status_next    = alle_pkg::STS_OK;
          read_data_next = '0;
          position_next  = cur;
          state_next     = alle_pkg::S_IDLE;
        end else begin
          lk_raddr   = cur;
          steps_next = steps - alle_pkg::LINK_W'(1);
          state_next = alle_pkg::S_FIND_WAIT;
        end
      end

      alle_pkg::S_FIND_WAIT: begin
        cur_next   = fwd ? lk_rdata.next[alle_pkg::IDX_W-1:0] : lk_rdata.prev;
        state_next = alle_pkg::S_FIND;
      end

      default: begin
        state_next = alle_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_full_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == alle_pkg::S_IDLE) |->
      ((free_head == alle_pkg::LINK_W'(alle_pkg::NODES)) ==
       (count == alle_pkg::IDX_W'(alle_pkg::NODES - 1))))
    else $error("free list state disagrees with stored count");

  a_empty_ring: assert property (@(posedge clk) disable iff (rst)
    (state == alle_pkg::S_IDLE && count == '0) |-> (head == '0 && tail == '0))
    else $error("empty list has a head or tail");

  a_insert_position: assert property (@(posedge clk) disable iff (rst)
    (done && status == alle_pkg::STS_OK && fn == alle_pkg::FN_INSERT) |-> (position != '0))
    else $error("insert reported the sentinel as its node");

  a_no_sentinel_erase: assert property (@(posedge clk) disable iff (rst)
    (lk_we && lk_waddr == '0 && state != alle_pkg::S_CLEAR) |-> lk_wdata.used)
    else $error("sentinel node marked free");
`endif

endmodule
